FILE: src/amq_pkg.sv
// Shared types and constants of the accel/mag attitude quaternion block.
// Depends on nothing; used by the top level accel_mag_attitude_quaternion.
package amq_pkg;

   localparam int FRAC_BITS_DEF = 14;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_ACCEL_ZERO = 2'd1,
      STAT_MAG_ZERO   = 2'd2,
      STAT_SINGULAR   = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] mag_x;
      logic signed [15:0] mag_y;
      logic signed [15:0] mag_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      status_type         status;
   } rsp_type;

endpackage

FILE: src/amq_sqrt_cell.sv
// One cell of a pipelined integer square root: retires one root bit per cycle.
// Standalone; chained in the top level.
module amq_sqrt_cell #(
   parameter int RW = 32
) (
   input  logic            clock,
   input  logic [RW+1:0]   prev_rem,
   input  logic [RW-1:0]   prev_root,
   input  logic [2*RW-1:0] prev_rad,
   output logic [RW+1:0]   rem_ff,
   output logic [RW-1:0]   root_ff,
   output logic [2*RW-1:0] rad_ff
);

   logic [RW+3:0]   remx;
   logic [RW+3:0]   trial;
   logic            ge;
   logic [RW+1:0]   rem_in;
   logic [RW-1:0]   root_in;
   logic [2*RW-1:0] rad_in;

   always_comb begin
      // bring down the next two radicand bits, try 4*root+1
      remx    = {prev_rem, prev_rad[2*RW-1 -: 2]};
      trial   = {2'b00, prev_root, 2'b01};
      ge      = (remx >= trial);
      rem_in  = ge ? (RW+2)'(remx - trial) : (RW+2)'(remx);
      root_in = {prev_root[RW-2:0], ge};
      rad_in  = {prev_rad[2*RW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
   end

endmodule

FILE: src/amq_div_cell.sv
// One cell of a pipelined restoring divider: retires one quotient bit per cycle.
// Standalone; chained in the top level.
module amq_div_cell #(
   parameter int DW = 32,
   parameter int QW = 15
) (
   input  logic          clock,
   input  logic [DW-1:0] prev_rem,
   input  logic [DW-1:0] prev_den,
   input  logic [QW-1:0] prev_quo,
   input  logic [QW-1:0] prev_num,
   output logic [DW-1:0] rem_ff,
   output logic [DW-1:0] den_ff,
   output logic [QW-1:0] quo_ff,
   output logic [QW-1:0] num_ff
);

   logic [DW:0]   t;
   logic [DW:0]   diff;
   logic          ge;
   logic [DW-1:0] rem_in;
   logic [QW-1:0] quo_in;
   logic [QW-1:0] num_in;

   always_comb begin
      t      = {prev_rem, prev_num[QW-1]};
      diff   = t - {1'b0, prev_den};
      ge     = (t >= {1'b0, prev_den});
      rem_in = ge ? diff[DW-1:0] : t[DW-1:0];
      quo_in = {prev_quo[QW-2:0], ge};
      num_in = {prev_num[QW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= prev_den;
      quo_ff <= quo_in;
      num_ff <= num_in;
   end

endmodule

FILE: src/amq_delay.sv
// Fixed-depth register delay line that carries side data past a cell chain.
// Standalone; instanced in the top level.
module amq_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

FILE: src/accel_mag_attitude_quaternion.sv
// Attitude quaternion from one accel and one mag sample, fully pipelined.
// Results are Q2.14 at FRAC_BITS = 14; the delay to rsp_strobe comes from the square-root
// chains (norms, dip sine, quaternion norm) and divider chains, one bit retired per cell.
// Throughput: one sample per cycle; busy is never raised, and since the receiver
// cannot stall, each result shows for exactly one cycle.
// Reset clears only the valid pipeline. Uses amq_pkg, amq_sqrt_cell, amq_div_cell, amq_delay.
module accel_mag_attitude_quaternion #(
   parameter int FRAC_BITS = amq_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  amq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output amq_pkg::rsp_type rsp_data
);

   localparam int SQA_RW  = 30;
   localparam int DIVU_QW = 31;
   localparam int DIVU_DW = 30;
   localparam int SQN_RW  = 31;
   localparam int SQQ_RW  = 32;
   localparam int DIVQ_QW = FRAC_BITS + 1;
   localparam int DIVQ_DW = 32;
   localparam int QNUM_W  = DIVQ_DW + DIVQ_QW;
   localparam int LAT     = 2 + SQA_RW + DIVU_QW + 4 + SQN_RW + 7 + SQQ_RW + DIVQ_QW + 1;
   localparam logic [DIVQ_QW-1:0] Q_ONE = DIVQ_QW'(1) << FRAC_BITS;

   logic accept;
   logic [LAT-1:0] vld_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // ---------------- input and squared norms ----------------
   logic [5:0][15:0] vec1_ff;
   logic [5:0][15:0] vec2_ff;
   logic [31:0]      sq2_ff [2];
   logic [1:0]       st2_ff;
   logic signed [31:0] vx [6];
   logic [31:0]      sq_in [2];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         vx[i] = 32'($signed(vec1_ff[i]));
      end
      sq_in[0] = 32'($unsigned(vx[0] * vx[0])) + 32'($unsigned(vx[1] * vx[1]))
               + 32'($unsigned(vx[2] * vx[2]));
      sq_in[1] = 32'($unsigned(vx[3] * vx[3])) + 32'($unsigned(vx[4] * vx[4]))
               + 32'($unsigned(vx[5] * vx[5]));
   end

   always_ff @(posedge clock) begin
      // lane 0 holds accel_x, lane 5 holds mag_z
      vec1_ff <= {req_data.mag_z, req_data.mag_y, req_data.mag_x,
                  req_data.accel_z, req_data.accel_y, req_data.accel_x};
      vec2_ff <= vec1_ff;
      sq2_ff  <= sq_in;
      if (sq_in[0] == '0) begin
         st2_ff <= amq_pkg::STAT_ACCEL_ZERO;
      end else if (sq_in[1] == '0) begin
         st2_ff <= amq_pkg::STAT_MAG_ZERO;
      end else begin
         st2_ff <= amq_pkg::STAT_OK;
      end
   end

   // ---------------- vector norms: sqrt(|v|^2 * 2^28) ----------------
   logic [SQA_RW+1:0]   sa_rem  [2][SQA_RW+1];
   logic [SQA_RW-1:0]   sa_root [2][SQA_RW+1];
   logic [2*SQA_RW-1:0] sa_rad  [2][SQA_RW+1];

   for (genvar v = 0; v < 2; v++) begin : g_sa
      assign sa_rem[v][0]  = '0;
      assign sa_root[v][0] = '0;
      assign sa_rad[v][0]  = {sq2_ff[v], 28'b0};
      for (genvar i = 0; i < SQA_RW; i++) begin : g_cell
         amq_sqrt_cell #(.RW(SQA_RW)) u_cell (
            .clock     (clock),
            .prev_rem  (sa_rem[v][i]),
            .prev_root (sa_root[v][i]),
            .prev_rad  (sa_rad[v][i]),
            .rem_ff    (sa_rem[v][i+1]),
            .root_ff   (sa_root[v][i+1]),
            .rad_ff    (sa_rad[v][i+1])
         );
      end
   end

   logic [5:0][15:0] veca;
   logic [1:0]       sta;

   amq_delay #(.W(98), .DEPTH(SQA_RW)) u_dly_a (
      .clock (clock),
      .din   ({vec2_ff, st2_ff}),
      .dout  ({veca, sta})
   );

   // ---------------- unit vectors: v * 2^44 / s ----------------
   logic [DIVU_DW-1:0] du_rem [6][DIVU_QW+1];
   logic [DIVU_DW-1:0] du_den [6][DIVU_QW+1];
   logic [DIVU_QW-1:0] du_quo [6][DIVU_QW+1];
   logic [DIVU_QW-1:0] du_num [6][DIVU_QW+1];
   logic [5:0]         sgn_a;

   for (genvar l = 0; l < 6; l++) begin : g_du
      logic [15:0] vmag;
      logic [59:0] unum;
      assign sgn_a[l] = veca[l][15];
      assign vmag     = veca[l][15] ? 16'(-veca[l]) : veca[l];
      assign unum     = {vmag, 44'b0} + 60'(sa_root[l/3][SQA_RW] >> 1);
      assign du_rem[l][0] = {1'b0, unum[59:31]};
      assign du_den[l][0] = sa_root[l/3][SQA_RW];
      assign du_quo[l][0] = '0;
      assign du_num[l][0] = unum[30:0];
      for (genvar i = 0; i < DIVU_QW; i++) begin : g_cell
         amq_div_cell #(.DW(DIVU_DW), .QW(DIVU_QW)) u_cell (
            .clock    (clock),
            .prev_rem (du_rem[l][i]),
            .prev_den (du_den[l][i]),
            .prev_quo (du_quo[l][i]),
            .prev_num (du_num[l][i]),
            .rem_ff   (du_rem[l][i+1]),
            .den_ff   (du_den[l][i+1]),
            .quo_ff   (du_quo[l][i+1]),
            .num_ff   (du_num[l][i+1])
         );
      end
   end

   logic [5:0] sgn_u;
   logic [1:0] stu;

   amq_delay #(.W(8), .DEPTH(DIVU_QW)) u_dly_u (
      .clock (clock),
      .din   ({sgn_a, sta}),
      .dout  ({sgn_u, stu})
   );

   // ---------------- clamp, dot product, dip angle ----------------
   logic signed [31:0] un_ff  [6];
   logic signed [31:0] un2_ff [6];
   logic signed [31:0] un3_ff [6];
   logic signed [31:0] un4_ff [6];
   logic signed [63:0] pd_ff  [3];
   logic signed [31:0] d3_ff;
   logic signed [31:0] d4_ff;
   logic [63:0]        dd4_ff;
   logic [1:0]         stu_ff, stp_ff, std_ff, stdd_ff;
   logic signed [31:0] un_in [6];
   logic signed [65:0] dot;
   logic [65:0]        dmag;
   logic [35:0]        dr;
   logic [31:0]        drc;
   logic signed [31:0] d_in;

   always_comb begin
      for (int l = 0; l < 6; l++) begin
         logic [30:0] qc;
         qc = (du_quo[l][DIVU_QW] > 31'(1 << 30)) ? 31'(1 << 30) : du_quo[l][DIVU_QW];
         un_in[l] = sgn_u[l] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
      end
      dot  = 66'(pd_ff[0]) + 66'(pd_ff[1]) + 66'(pd_ff[2]);
      dmag = dot[65] ? 66'($unsigned(-dot)) : 66'($unsigned(dot));
      dr   = 36'((dmag + (66'(1) << 29)) >> 30);
      drc  = (dr > 36'(1 << 30)) ? 32'(1 << 30) : dr[31:0];
      d_in = dot[65] ? -$signed(drc) : $signed(drc);
   end

   always_ff @(posedge clock) begin
      un_ff  <= un_in;
      stu_ff <= stu;
      for (int i = 0; i < 3; i++) begin
         pd_ff[i] <= 64'(un_ff[i] * un_ff[i+3]);
      end
      un2_ff  <= un_ff;
      stp_ff  <= stu_ff;
      un3_ff  <= un2_ff;
      d3_ff   <= d_in;
      std_ff  <= stp_ff;
      un4_ff  <= un3_ff;
      d4_ff   <= d3_ff;
      dd4_ff  <= $unsigned(64'(d3_ff * d3_ff));
      stdd_ff <= std_ff;
   end

   // ---------------- sine of dip: sqrt(2^60 - d^2) ----------------
   logic [SQN_RW+1:0]   sn_rem  [SQN_RW+1];
   logic [SQN_RW-1:0]   sn_root [SQN_RW+1];
   logic [2*SQN_RW-1:0] sn_rad  [SQN_RW+1];

   assign sn_rem[0]  = '0;
   assign sn_root[0] = '0;
   assign sn_rad[0]  = (62'(1) << 60) - dd4_ff[61:0];

   for (genvar i = 0; i < SQN_RW; i++) begin : g_sn
      amq_sqrt_cell #(.RW(SQN_RW)) u_cell (
         .clock     (clock),
         .prev_rem  (sn_rem[i]),
         .prev_root (sn_root[i]),
         .prev_rad  (sn_rad[i]),
         .rem_ff    (sn_rem[i+1]),
         .root_ff   (sn_root[i+1]),
         .rad_ff    (sn_rad[i+1])
      );
   end

   logic [5:0][31:0] un4_pk;
   logic [5:0][31:0] unn_pk;
   logic [31:0]      dn_pk;
   logic [1:0]       stn;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         un4_pk[i] = un4_ff[i];
      end
   end

   amq_delay #(.W(226), .DEPTH(SQN_RW)) u_dly_n (
      .clock (clock),
      .din   ({un4_pk, d4_ff, stdd_ff}),
      .dout  ({unn_pk, dn_pk, stn})
   );

   // ---------------- raw quaternion components ----------------
   logic signed [65:0] p_ff [8];
   logic signed [31:0] mz_ff;
   logic [1:0]         str1_ff, str2_ff, str3_ff;
   logic signed [67:0] r_ff [4];
   logic [31:0]        rm3_ff [4];
   logic [3:0]         neg3_ff;
   logic signed [32:0] an [3];
   logic signed [32:0] mn [3];
   logic signed [32:0] nn, dn, snm, az1, dmz;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         an[i] = 33'($signed(unn_pk[i]));
         mn[i] = 33'($signed(unn_pk[i+3]));
      end
      nn  = $signed({2'b00, sn_root[SQN_RW]});
      dn  = 33'($signed(dn_pk));
      snm = nn + mn[0];
      az1 = an[2] - 33'(1 << 30);
      dmz = dn - mn[2];
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= an[1] * snm;
      p_ff[1] <= an[0] * mn[1];
      p_ff[2] <= az1 * snm;
      p_ff[3] <= an[0] * dmz;
      p_ff[4] <= az1 * mn[1];
      p_ff[5] <= an[1] * dmz;
      p_ff[6] <= an[2] * dn;
      p_ff[7] <= an[0] * nn;
      mz_ff   <= unn_pk[5];
      str1_ff <= stn;
      r_ff[0] <= 68'(p_ff[1]) - 68'(p_ff[0]);
      r_ff[1] <= 68'(p_ff[2]) + 68'(p_ff[3]);
      r_ff[2] <= 68'(p_ff[4]) + 68'(p_ff[5]);
      r_ff[3] <= 68'(p_ff[6]) - 68'(p_ff[7]) - (68'(mz_ff) <<< 30);
      str2_ff <= str1_ff;
      str3_ff <= str2_ff;
   end

   // round Q.60 to Q.28, half away from zero
   logic [31:0] rm_in  [4];
   logic [3:0]  neg_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic [67:0] rmag;
         rmag      = r_ff[i][67] ? 68'($unsigned(-r_ff[i])) : 68'($unsigned(r_ff[i]));
         rm_in[i]  = 32'((rmag + (68'(1) << 31)) >> 32);
         neg_in[i] = r_ff[i][67] && (rm_in[i] != '0);
      end
   end

   always_ff @(posedge clock) begin
      rm3_ff  <= rm_in;
      neg3_ff <= neg_in;
   end

   // ---------------- normalize and take the norm ----------------
   logic [31:0] orv;
   logic [4:0]  msb;
   logic [4:0]  k_in;
   logic [4:0]  k4_ff;
   logic [31:0] rm4_ff [4];
   logic [31:0] rm5_ff [4];
   logic [31:0] rm6_ff [4];
   logic [31:0] rm7_ff [4];
   logic [3:0]  neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic [1:0]  st4_ff, st5_ff, st6_ff, st7_ff;
   logic [63:0] sqr6_ff [4];
   logic [63:0] qsq7_ff;

   always_comb begin
      orv = rm3_ff[0] | rm3_ff[1] | rm3_ff[2] | rm3_ff[3];
      msb = '0;
      for (int i = 0; i < 32; i++) begin
         if (orv[i]) begin
            msb = 5'(i);
         end
      end
      k_in = (msb >= 5'd29) ? 5'd0 : 5'd29 - msb;
   end

   always_ff @(posedge clock) begin
      rm4_ff  <= rm3_ff;
      neg4_ff <= neg3_ff;
      k4_ff   <= k_in;
      if (str3_ff == amq_pkg::STAT_OK && orv == '0) begin
         st4_ff <= amq_pkg::STAT_SINGULAR;
      end else begin
         st4_ff <= str3_ff;
      end
      for (int i = 0; i < 4; i++) begin
         rm5_ff[i]  <= rm4_ff[i] << k4_ff;
         sqr6_ff[i] <= 64'(rm5_ff[i]) * 64'(rm5_ff[i]);
      end
      neg5_ff <= neg4_ff;
      st5_ff  <= st4_ff;
      rm6_ff  <= rm5_ff;
      neg6_ff <= neg5_ff;
      st6_ff  <= st5_ff;
      // sum of squares wraps at 64 bits
      qsq7_ff <= sqr6_ff[0] + sqr6_ff[1] + sqr6_ff[2] + sqr6_ff[3];
      rm7_ff  <= rm6_ff;
      neg7_ff <= neg6_ff;
      st7_ff  <= st6_ff;
   end

   logic [SQQ_RW+1:0]   sq_rem  [SQQ_RW+1];
   logic [SQQ_RW-1:0]   sq_root [SQQ_RW+1];
   logic [2*SQQ_RW-1:0] sq_rad  [SQQ_RW+1];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = qsq7_ff;

   for (genvar i = 0; i < SQQ_RW; i++) begin : g_sq
      amq_sqrt_cell #(.RW(SQQ_RW)) u_cell (
         .clock     (clock),
         .prev_rem  (sq_rem[i]),
         .prev_root (sq_root[i]),
         .prev_rad  (sq_rad[i]),
         .rem_ff    (sq_rem[i+1]),
         .root_ff   (sq_root[i+1]),
         .rad_ff    (sq_rad[i+1])
      );
   end

   logic [3:0][31:0] rm7_pk;
   logic [3:0][31:0] rmq_pk;
   logic [3:0]       negq;
   logic [1:0]       stq;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rm7_pk[i] = rm7_ff[i];
      end
   end

   amq_delay #(.W(134), .DEPTH(SQQ_RW)) u_dly_q (
      .clock (clock),
      .din   ({rm7_pk, neg7_ff, st7_ff}),
      .dout  ({rmq_pk, negq, stq})
   );

   // ---------------- final scaling: |r| * 2^FRAC_BITS / n ----------------
   logic [DIVQ_DW-1:0] dq_rem [4][DIVQ_QW+1];
   logic [DIVQ_DW-1:0] dq_den [4][DIVQ_QW+1];
   logic [DIVQ_QW-1:0] dq_quo [4][DIVQ_QW+1];
   logic [DIVQ_QW-1:0] dq_num [4][DIVQ_QW+1];
   logic [3:0]         satq;

   for (genvar l = 0; l < 4; l++) begin : g_dq
      logic [QNUM_W-1:0] qnum;
      assign qnum    = (QNUM_W'(rmq_pk[l]) << FRAC_BITS) + QNUM_W'(sq_root[SQQ_RW] >> 1);
      assign satq[l] = rmq_pk[l] > sq_root[SQQ_RW];
      assign dq_rem[l][0] = qnum[QNUM_W-1:DIVQ_QW];
      assign dq_den[l][0] = sq_root[SQQ_RW];
      assign dq_quo[l][0] = '0;
      assign dq_num[l][0] = qnum[DIVQ_QW-1:0];
      for (genvar i = 0; i < DIVQ_QW; i++) begin : g_cell
         amq_div_cell #(.DW(DIVQ_DW), .QW(DIVQ_QW)) u_cell (
            .clock    (clock),
            .prev_rem (dq_rem[l][i]),
            .prev_den (dq_den[l][i]),
            .prev_quo (dq_quo[l][i]),
            .prev_num (dq_num[l][i]),
            .rem_ff   (dq_rem[l][i+1]),
            .den_ff   (dq_den[l][i+1]),
            .quo_ff   (dq_quo[l][i+1]),
            .num_ff   (dq_num[l][i+1])
         );
      end
   end

   logic [3:0] sato;
   logic [3:0] nego;
   logic [1:0] sto;

   amq_delay #(.W(10), .DEPTH(DIVQ_QW)) u_dly_o (
      .clock (clock),
      .din   ({satq, negq, stq}),
      .dout  ({sato, nego, sto})
   );

   logic [15:0] qf [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         logic [DIVQ_QW-1:0] qc;
         logic [31:0]        q32;
         qc    = (sato[l] || dq_quo[l][DIVQ_QW] > Q_ONE) ? Q_ONE : dq_quo[l][DIVQ_QW];
         q32   = 32'(qc);
         q32   = nego[l] ? 32'(-q32) : q32;
         qf[l] = (sto == amq_pkg::STAT_OK) ? q32[15:0] : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data.quat_w <= qf[3];
      rsp_data.quat_x <= qf[0];
      rsp_data.quat_y <= qf[1];
      rsp_data.quat_z <= qf[2];
      rsp_data.status <= amq_pkg::status_type'(sto);
   end

   assign rsp_strobe = vld_ff[LAT-1];

   // ---------------- checks ----------------
   a_lat : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_strobe)
      else $error("accepted beat did not come out after the pipeline latency");

   a_accel_zero : assert property (@(posedge clock) disable iff (reset)
      accept && req_data.accel_x == '0 && req_data.accel_y == '0 && req_data.accel_z == '0
      |-> ##LAT rsp_data.status == amq_pkg::STAT_ACCEL_ZERO)
      else $error("zero accel beat did not report accel zero");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != amq_pkg::STAT_OK
      |-> rsp_data.quat_w == '0 && rsp_data.quat_x == '0
          && rsp_data.quat_y == '0 && rsp_data.quat_z == '0)
      else $error("error result carries a nonzero quaternion");

endmodule
